### rtl/stq_pkg.sv
// Shared types, constants and helpers of the sorted timer queue.
// No dependencies; stq_if, stq_scan, the top level and stq_checker use this package.
`default_nettype none

package stq_pkg;

  localparam int NumTimers = 16;
  localparam int TimeBits  = 48;
  localparam int SlotW     = $clog2(NumTimers);
  localparam int CntW      = SlotW + 1;

  localparam int ExpW = 48;
  localparam int IvlW = 32;
  localparam int IdW  = 4;
  localparam int SumW = ((TimeBits > IvlW) ? TimeBits : IvlW) + 1;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [ExpW-1:0]     exp_field_t;
  typedef logic [IvlW-1:0]     ivl_field_t;
  typedef logic [IdW-1:0]      id_field_t;
  typedef logic [SumW-1:0]     sum_t;

  localparam time_t TimeMax = '1;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_NEXT    = 2'd2
  } kind_e;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef enum logic {
    SCAN_MIN = 1'b0,
    SCAN_DUE = 1'b1
  } scan_mode_e;

  typedef struct packed {
    logic       start;
    scan_mode_e mode;
    time_t      now;
    logic       has_prev;
    time_t      prev_exp;
    slot_t      prev_slot;
  } scan_req_t;

  typedef struct packed {
    logic  done;
    logic  found;
    time_t best_exp;
    slot_t best_slot;
    logic  free_found;
    slot_t free_slot;
  } scan_rsp_t;

  // Reload point of a periodic timer, saturating at the top of the time range.
  function automatic time_t reload_time(time_t now, ivl_field_t ivl);
    sum_t sum;
    sum = sum_t'(now) + sum_t'(ivl);
    if (sum > sum_t'(TimeMax)) begin
      return TimeMax;
    end
    return time_t'(sum);
  endfunction

endpackage

`default_nettype wire

### rtl/stq_if.sv
// Valid/ready channel interfaces for the timer queue's item and result streams.
// Depends on stq_pkg for the field widths.
`default_nettype none

interface stq_in_if;
  import stq_pkg::*;
  logic       valid;
  logic       ready;
  logic       mode;
  exp_field_t expire_time;
  ivl_field_t interval_us;
  exp_field_t now_time;

  modport source (output valid, mode, expire_time, interval_us, now_time, input ready);
  modport sink   (input valid, mode, expire_time, interval_us, now_time, output ready);
endinterface

interface stq_out_if;
  import stq_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  id_field_t  timer_id;
  logic       earliest_changed;
  logic       queue_full;
  exp_field_t next_expire;
  logic       next_valid;
  logic       last;

  modport source (output valid, kind, timer_id, earliest_changed, queue_full, next_expire,
                  next_valid, last, input ready);
  modport sink   (input valid, kind, timer_id, earliest_changed, queue_full, next_expire,
                  next_valid, last, output ready);
endinterface

`default_nettype wire

### rtl/stq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module stq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/stq_scan.sv
// Shared scan unit: walks every slot once, one per cycle, through the expiry RAM.
// Finds the earliest expiry, or next due timer, and the first free slot. Uses stq_pkg.
`default_nettype none

module stq_scan (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire stq_pkg::scan_req_t          req_i,
  input  wire logic [stq_pkg::NumTimers-1:0] valid_i,
  output stq_pkg::slot_t                   rd_addr_o,
  input  wire stq_pkg::time_t              rd_data_i,
  output stq_pkg::scan_rsp_t               rsp_o
);
  import stq_pkg::*;

  logic       busy_q;
  slot_t      cnt_q;
  logic       s1_vld_q;
  slot_t      s1_slot_q;
  logic       done_q;
  logic       found_q;
  logic       free_found_q;
  time_t      best_exp_q;
  slot_t      best_slot_q;
  slot_t      free_slot_q;
  scan_mode_e mode_q;
  time_t      now_q;
  logic       has_prev_q;
  time_t      prev_exp_q;
  slot_t      prev_slot_q;

  logic cur_v;
  logic after_prev;
  logic elig;
  logic take;
  logic free_take;

  assign rd_addr_o = cnt_q;

  // The read data of the slot issued in the previous cycle is compared here.
  // A due timer qualifies only if its (expiry, slot) key lies above the one found last.
  always_comb begin
    cur_v      = valid_i[s1_slot_q];
    after_prev = !has_prev_q || (rd_data_i > prev_exp_q) ||
                 ((rd_data_i == prev_exp_q) && (s1_slot_q > prev_slot_q));
    elig       = cur_v && ((mode_q == SCAN_MIN) || ((rd_data_i <= now_q) && after_prev));
    take       = s1_vld_q && elig && (!found_q || (rd_data_i < best_exp_q));
    free_take  = s1_vld_q && !cur_v && !free_found_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      cnt_q        <= '0;
      s1_vld_q     <= 1'b0;
      done_q       <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      done_q <= s1_vld_q && (s1_slot_q == slot_t'(NumTimers - 1));
      if (req_i.start) begin
        busy_q       <= 1'b1;
        cnt_q        <= '0;
        s1_vld_q     <= 1'b0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        s1_vld_q <= busy_q;
        if (busy_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == slot_t'(NumTimers - 1)) begin
            busy_q <= 1'b0;
          end
        end
        if (take) begin
          found_q <= 1'b1;
        end
        if (free_take) begin
          free_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_slot_q <= cnt_q;
    if (req_i.start) begin
      mode_q      <= req_i.mode;
      now_q       <= req_i.now;
      has_prev_q  <= req_i.has_prev;
      prev_exp_q  <= req_i.prev_exp;
      prev_slot_q <= req_i.prev_slot;
    end
    if (take) begin
      best_exp_q  <= rd_data_i;
      best_slot_q <= s1_slot_q;
    end
    if (free_take) begin
      free_slot_q <= s1_slot_q;
    end
  end

  always_comb begin
    rsp_o.done       = done_q;
    rsp_o.found      = found_q;
    rsp_o.best_exp   = best_exp_q;
    rsp_o.best_slot  = best_slot_q;
    rsp_o.free_found = free_found_q;
    rsp_o.free_slot  = free_slot_q;
  end

endmodule

`default_nettype wire

### rtl/sorted_timer_queue.sv
// Top level of the sorted timer queue: sequencer, slot state and result register.
// Uses stq_pkg, stq_if, stq_ram and stq_scan.
//
//   channel    dir   handshake      carries
//   item_i     in    valid/ready    mode, expire_time, interval_us, now_time
//   result_o   out   valid/ready    kind, timer_id, earliest_changed, queue_full,
//                                   next_expire, next_valid, last
//
// One scan unit reads the expiry RAM a slot per cycle. An add takes one scan pass and
// one result; a tick with k due timers takes k + 2 passes, a reload read and write per
// due timer and k + 1 results.
// Reset clears the slot valid flags and the sequencer; no clearing pass is needed.
// A stalled result holds in the output register; a new item is taken while it waits.
`default_nettype none

module sorted_timer_queue (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stq_in_if.sink     item_i,
  stq_out_if.source  result_o
);
  import stq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_RLD_RD = 5'b00100,
    ST_RLD_WR = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   is_tick_q, is_tick_d;
  logic   final_q, final_d;
  time_t  exp_q, exp_d;
  ivl_field_t ivl_q, ivl_d;
  time_t  now_q, now_d;
  cnt_t   cnt_q, cnt_d;
  cnt_t   idx_q, idx_d;
  logic   prev_vld_q, prev_vld_d;
  time_t  prev_exp_q, prev_exp_d;
  slot_t  prev_slot_q, prev_slot_d;
  slot_t  res_id_q, res_id_d;
  logic   res_chg_q, res_chg_d;
  logic   res_full_q, res_full_d;
  time_t  next_exp_q, next_exp_d;
  logic   next_vld_q, next_vld_d;

  logic [NumTimers-1:0] slot_valid_q;
  slot_t id_buf_q [NumTimers];

  logic  out_vld_q;
  kind_e out_kind_q;
  slot_t out_id_q;
  logic  out_chg_q;
  logic  out_full_q;
  time_t out_next_exp_q;
  logic  out_next_vld_q;
  logic  out_last_q;

  logic  out_load;
  kind_e out_kind;
  slot_t out_id;
  logic  out_chg;
  logic  out_full;
  logic  out_last;

  scan_req_t  scan_req;
  scan_rsp_t  scan_rsp;
  logic       scan_start;
  scan_mode_e scan_mode;
  slot_t      exp_raddr;
  time_t      exp_rdata;
  logic       exp_we;
  slot_t      exp_waddr;
  time_t      exp_wdata;
  logic       ivl_we;
  ivl_field_t ivl_rdata;
  logic       set_vld;
  logic       clr_vld;
  slot_t      vld_slot;
  logic       buf_we;
  slot_t      buf_slot;
  logic       add_chg;

  assign item_i.ready = (state_q == ST_IDLE);
  assign buf_slot     = id_buf_q[idx_q[SlotW-1:0]];
  assign add_chg      = !scan_rsp.found || (exp_q < scan_rsp.best_exp);

  stq_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (scan_req),
    .valid_i   (slot_valid_q),
    .rd_addr_o (exp_raddr),
    .rd_data_i (exp_rdata),
    .rsp_o     (scan_rsp)
  );

  stq_ram #(.Width(TimeBits), .Depth(NumTimers)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (exp_waddr),
    .wdata_i (exp_wdata),
    .raddr_i (exp_raddr),
    .rdata_o (exp_rdata)
  );

  stq_ram #(.Width(IvlW), .Depth(NumTimers)) u_ivl_ram (
    .clk_i   (clk_i),
    .we_i    (ivl_we),
    .waddr_i (res_id_d),
    .wdata_i (ivl_q),
    .raddr_i (buf_slot),
    .rdata_o (ivl_rdata)
  );

  always_comb begin
    state_d     = state_q;
    is_tick_d   = is_tick_q;
    final_d     = final_q;
    exp_d       = exp_q;
    ivl_d       = ivl_q;
    now_d       = now_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    prev_vld_d  = prev_vld_q;
    prev_exp_d  = prev_exp_q;
    prev_slot_d = prev_slot_q;
    res_id_d    = res_id_q;
    res_chg_d   = res_chg_q;
    res_full_d  = res_full_q;
    next_exp_d  = next_exp_q;
    next_vld_d  = next_vld_q;
    scan_start  = 1'b0;
    scan_mode   = SCAN_MIN;
    exp_we      = 1'b0;
    exp_waddr   = res_id_q;
    exp_wdata   = exp_q;
    ivl_we      = 1'b0;
    set_vld     = 1'b0;
    clr_vld     = 1'b0;
    vld_slot    = res_id_q;
    buf_we      = 1'b0;
    out_load    = 1'b0;
    out_kind    = KIND_NEXT;
    out_id      = '0;
    out_chg     = 1'b0;
    out_full    = 1'b0;
    out_last    = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          is_tick_d  = (item_i.mode == MODE_TICK);
          exp_d      = time_t'(item_i.expire_time);
          ivl_d      = item_i.interval_us;
          now_d      = time_t'(item_i.now_time);
          cnt_d      = '0;
          final_d    = 1'b0;
          prev_vld_d = 1'b0;
          scan_start = 1'b1;
          scan_mode  = (item_i.mode == MODE_TICK) ? SCAN_DUE : SCAN_MIN;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          if (!is_tick_q) begin
            idx_d   = '0;
            state_d = ST_EMIT;
            if (scan_rsp.free_found) begin
              res_id_d   = scan_rsp.free_slot;
              res_chg_d  = add_chg;
              res_full_d = 1'b0;
              next_exp_d = add_chg ? exp_q : scan_rsp.best_exp;
              next_vld_d = 1'b1;
              exp_we     = 1'b1;
              exp_waddr  = scan_rsp.free_slot;
              ivl_we     = 1'b1;
              set_vld    = 1'b1;
              vld_slot   = scan_rsp.free_slot;
            end else begin
              res_id_d   = '0;
              res_chg_d  = 1'b0;
              res_full_d = 1'b1;
              next_exp_d = scan_rsp.found ? scan_rsp.best_exp : '0;
              next_vld_d = scan_rsp.found;
            end
          end else if (final_q) begin
            next_exp_d = scan_rsp.found ? scan_rsp.best_exp : '0;
            next_vld_d = scan_rsp.found;
            idx_d      = '0;
            state_d    = ST_EMIT;
          end else if (scan_rsp.found) begin
            // Record the due timer and look for the next one past its key.
            buf_we      = 1'b1;
            cnt_d       = cnt_q + 1'b1;
            prev_vld_d  = 1'b1;
            prev_exp_d  = scan_rsp.best_exp;
            prev_slot_d = scan_rsp.best_slot;
            scan_start  = 1'b1;
            scan_mode   = SCAN_DUE;
          end else if (cnt_q != '0) begin
            idx_d   = '0;
            state_d = ST_RLD_RD;
          end else begin
            final_d    = 1'b1;
            scan_start = 1'b1;
            scan_mode  = SCAN_MIN;
          end
        end
      end
      ST_RLD_RD: begin
        state_d = ST_RLD_WR;
      end
      ST_RLD_WR: begin
        if (ivl_rdata != '0) begin
          exp_we    = 1'b1;
          exp_waddr = buf_slot;
          exp_wdata = reload_time(now_q, ivl_rdata);
        end else begin
          clr_vld  = 1'b1;
          vld_slot = buf_slot;
        end
        idx_d = idx_q + 1'b1;
        if (idx_d == cnt_q) begin
          final_d    = 1'b1;
          scan_start = 1'b1;
          scan_mode  = SCAN_MIN;
          state_d    = ST_SCAN;
        end else begin
          state_d = ST_RLD_RD;
        end
      end
      ST_EMIT: begin
        if (!out_vld_q || result_o.ready) begin
          out_load = 1'b1;
          if (!is_tick_q) begin
            out_kind = KIND_ADD;
            out_id   = res_id_q;
            out_chg  = res_chg_q;
            out_full = res_full_q;
            state_d  = ST_IDLE;
          end else if (idx_q < cnt_q) begin
            out_kind = KIND_EXPIRED;
            out_id   = buf_slot;
            out_last = 1'b0;
            idx_d    = idx_q + 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    scan_req.start     = scan_start;
    scan_req.mode      = scan_mode;
    scan_req.now       = now_d;
    scan_req.has_prev  = prev_vld_d;
    scan_req.prev_exp  = prev_exp_d;
    scan_req.prev_slot = prev_slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      is_tick_q    <= 1'b0;
      final_q      <= 1'b0;
      cnt_q        <= '0;
      idx_q        <= '0;
      prev_vld_q   <= 1'b0;
      slot_valid_q <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      is_tick_q  <= is_tick_d;
      final_q    <= final_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      prev_vld_q <= prev_vld_d;
      if (set_vld) begin
        slot_valid_q[vld_slot] <= 1'b1;
      end
      if (clr_vld) begin
        slot_valid_q[vld_slot] <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q       <= exp_d;
    ivl_q       <= ivl_d;
    now_q       <= now_d;
    prev_exp_q  <= prev_exp_d;
    prev_slot_q <= prev_slot_d;
    res_id_q    <= res_id_d;
    res_chg_q   <= res_chg_d;
    res_full_q  <= res_full_d;
    next_exp_q  <= next_exp_d;
    next_vld_q  <= next_vld_d;
    if (buf_we) begin
      id_buf_q[cnt_q[SlotW-1:0]] <= scan_rsp.best_slot;
    end
    // The next-expiry fields are copied too, since a new item may change the
    // sequencer's copy while this result still waits.
    if (out_load) begin
      out_kind_q     <= out_kind;
      out_id_q       <= out_id;
      out_chg_q      <= out_chg;
      out_full_q     <= out_full;
      out_last_q     <= out_last;
      out_next_exp_q <= next_exp_q;
      out_next_vld_q <= next_vld_q;
    end
  end

  assign result_o.valid            = out_vld_q;
  assign result_o.kind             = out_kind_q;
  assign result_o.timer_id         = id_field_t'(out_id_q);
  assign result_o.earliest_changed = out_chg_q;
  assign result_o.queue_full       = out_full_q;
  assign result_o.next_expire      = exp_field_t'(out_next_exp_q);
  assign result_o.next_valid       = out_next_vld_q;
  assign result_o.last             = out_last_q;

endmodule

`default_nettype wire

### rtl/stq_checker.sv
// Port-level checks of the sorted timer queue, bound to its top level.
// Uses stq_pkg for the result kind codes.
`default_nettype none

module stq_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [1:0]             kind_i,
  input wire stq_pkg::id_field_t     timer_id_i,
  input wire logic                   chg_i,
  input wire logic                   full_i,
  input wire stq_pkg::exp_field_t    next_exp_i,
  input wire logic                   next_vld_i,
  input wire logic                   last_i
);
  import stq_pkg::*;

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({kind_i, timer_id_i, chg_i, full_i, next_exp_i, next_vld_i, last_i}))
    else $error("stalled result changed");

  // Only expired-timer results are followed by more results of the same item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (kind_i != KIND_EXPIRED)))
    else $error("last flag does not match result kind");

  // A rejected add carries no slot and no earliest change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && full_i |-> (kind_i == KIND_ADD) && (timer_id_i == '0) && !chg_i)
    else $error("malformed queue-full result");

  // An empty queue reports a zero expiry and cannot have gained an earliest timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !next_vld_i |-> (next_exp_i == '0) && !chg_i)
    else $error("empty queue with nonzero next expiry");

  // While expired timers of a tick wait, the final report is still owed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_EXPIRED) |-> !in_ready_i)
    else $error("new item taken before tick report");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .kind_i      (result_o.kind),
  .timer_id_i  (result_o.timer_id),
  .chg_i       (result_o.earliest_changed),
  .full_i      (result_o.queue_full),
  .next_exp_i  (result_o.next_expire),
  .next_vld_i  (result_o.next_valid),
  .last_i      (result_o.last)
);

`default_nettype wire
